@@ sv/priority_message_queue_core_defines.svh @@
// assertion macros for the priority message queue checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PRIORITY_MESSAGE_QUEUE_CORE_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pmq_pkg.sv @@
// shared constants, codes and control types of the priority message queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pmq_pkg;

  localparam int unsigned PMQ_QUEUE_DEPTH   = 16;
  localparam int unsigned PMQ_PRIORITY_BITS = 8;
  localparam int unsigned PMQ_PAYLOAD_BITS  = 32;

  localparam int unsigned STATUS_W = 3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PUSH_EMPTY  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSHED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PUSH_REFUSE = 3'd4;

  typedef struct packed {
    logic load_in;  // capture the accepted word into the operand register
    logic exec;     // run the operation on the cell chain and load the result
  } pmq_cmd_t;

endpackage

`default_nettype wire

@@ sv/pmq_if.sv @@
// valid/ready channel interfaces for request and result words
// depends on pmq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pmq_in_if #(
  parameter int unsigned PRIORITY_BITS = pmq_pkg::PMQ_PRIORITY_BITS,
  parameter int unsigned PAYLOAD_BITS  = pmq_pkg::PMQ_PAYLOAD_BITS
);
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [PRIORITY_BITS-1:0] item_priority;
  logic [PAYLOAD_BITS-1:0]  payload_tag;

  modport source (output valid, opcode, item_priority, payload_tag, input ready);
  modport sink   (input valid, opcode, item_priority, payload_tag, output ready);
endinterface

interface pmq_out_if #(
  parameter int unsigned QUEUE_DEPTH   = pmq_pkg::PMQ_QUEUE_DEPTH,
  parameter int unsigned PRIORITY_BITS = pmq_pkg::PMQ_PRIORITY_BITS,
  parameter int unsigned PAYLOAD_BITS  = pmq_pkg::PMQ_PAYLOAD_BITS
);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [pmq_pkg::STATUS_W-1:0]  status;
  logic [PRIORITY_BITS-1:0]      out_priority;
  logic [PAYLOAD_BITS-1:0]       out_payload;
  logic [CNT_W-1:0]              pending_count;
  logic [PRIORITY_BITS-1:0]      serving_priority;

  modport source (output valid, status, out_priority, out_payload, pending_count,
                  serving_priority, input ready);
  modport sink   (input valid, status, out_priority, out_payload, pending_count,
                  serving_priority, output ready);
endinterface

`default_nettype wire

@@ sv/priority_message_queue_core.sv @@
// Priority message queue, top level.
// Request channel in_i carries opcode (push or pop), item_priority and
// payload_tag; result channel out_o carries status, out_priority,
// out_payload, pending_count and serving_priority. Both are valid/ready,
// a word moves at a rising edge with valid and ready high.
// Messages sit in a chain of QUEUE_DEPTH cells, highest priority at the
// head, equal priorities in arrival order. A push lands by shifting
// every cell below its spot down by one; a pop shifts all up.
// A request is taken into the operand register in the idle state; the
// execute state then runs it on the cell chain and loads the result
// register once that register is free or draining. A new request is taken
// only after the previous one has executed; this is set by the two-state
// controller around the single operand register.
// When out_o stalls the result holds in its register; the next request is
// still accepted and then waits in execute until the result is taken.
// Reset (rst_ni low, asynchronous) empties the queue, drops any pending
// result and sets the serving priority to 1. Cell contents are not cleared.
// depends on pmq_pkg, pmq_if, pmq_ctrl, pmq_datapath
`timescale 1ns / 1ps
`default_nettype none

module priority_message_queue_core #(
  parameter int unsigned QUEUE_DEPTH   = pmq_pkg::PMQ_QUEUE_DEPTH,
  parameter int unsigned PRIORITY_BITS = pmq_pkg::PMQ_PRIORITY_BITS,
  parameter int unsigned PAYLOAD_BITS  = pmq_pkg::PMQ_PAYLOAD_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pmq_in_if.sink     in_i,
  pmq_out_if.source  out_o
);
  import pmq_pkg::*;

  pmq_cmd_t cmd;

  pmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  pmq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .PAYLOAD_BITS  (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .opcode_i           (in_i.opcode),
    .item_priority_i    (in_i.item_priority),
    .payload_tag_i      (in_i.payload_tag),
    .status_o           (out_o.status),
    .out_priority_o     (out_o.out_priority),
    .out_payload_o      (out_o.out_payload),
    .pending_count_o    (out_o.pending_count),
    .serving_priority_o (out_o.serving_priority)
  );

endmodule

`default_nettype wire

@@ sv/pmq_ctrl.sv @@
// controller of the priority message queue: operand capture, execute, result valid
// depends on pmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output pmq_pkg::pmq_cmd_t      cmd_o
);
  import pmq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.load_in = (state_q == S_IDLE) && in_valid_i;
  // the result register must be free or draining this cycle
  assign cmd_o.exec    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/pmq_datapath.sv @@
// datapath of the priority message queue: operand register, sorted cell chain,
// count, serving priority and result register; depends on pmq_pkg
`timescale 1ns / 1ps
`default_nettype none

module pmq_datapath #(
  parameter int unsigned QUEUE_DEPTH   = pmq_pkg::PMQ_QUEUE_DEPTH,
  parameter int unsigned PRIORITY_BITS = pmq_pkg::PMQ_PRIORITY_BITS,
  parameter int unsigned PAYLOAD_BITS  = pmq_pkg::PMQ_PAYLOAD_BITS,
  localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pmq_pkg::pmq_cmd_t             cmd_i,
  input  wire logic                          opcode_i,
  input  wire logic [PRIORITY_BITS-1:0]      item_priority_i,
  input  wire logic [PAYLOAD_BITS-1:0]       payload_tag_i,
  output logic [pmq_pkg::STATUS_W-1:0]       status_o,
  output logic [PRIORITY_BITS-1:0]           out_priority_o,
  output logic [PAYLOAD_BITS-1:0]            out_payload_o,
  output logic [CNT_W-1:0]                   pending_count_o,
  output logic [PRIORITY_BITS-1:0]           serving_priority_o
);
  import pmq_pkg::*;

  // operand register
  logic                     op_q;
  logic [PRIORITY_BITS-1:0] pri_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;

  // cell chain, slot 0 at the head
  logic [PRIORITY_BITS-1:0] slot_pri_q [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  slot_pay_q [QUEUE_DEPTH];

  logic [CNT_W-1:0]         count_q, count_d;
  logic [PRIORITY_BITS-1:0] serving_q, serving_d;

  // result register
  logic [STATUS_W-1:0]      res_status_q, res_status_d;
  logic [PRIORITY_BITS-1:0] res_pri_q, res_pri_d;
  logic [PAYLOAD_BITS-1:0]  res_pay_q, res_pay_d;
  logic [CNT_W-1:0]         res_cnt_q;
  logic [PRIORITY_BITS-1:0] res_serv_q;

  logic full, empty, do_push, do_pop;
  logic [QUEUE_DEPTH-1:0] lower;   // held cell with a lower priority than the operand
  logic [QUEUE_DEPTH-1:0] ins_at;  // cell that takes the new word
  logic [QUEUE_DEPTH-1:0] shift_dn;

  logic [PRIORITY_BITS-1:0] prev_pri [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  prev_pay [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] next_pri [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  next_pay [QUEUE_DEPTH];

  assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = cmd_i.exec && (op_q == OP_PUSH) && !full;
  assign do_pop  = cmd_i.exec && (op_q == OP_POP) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic prev_lower;
    assign lower[g] = (CNT_W'(g) < count_q) && (slot_pri_q[g] < pri_q);
    if (g == 0) begin : g_head
      assign prev_lower  = 1'b0;
      assign prev_pri[g] = pri_q;
      assign prev_pay[g] = pay_q;
    end else begin : g_body
      assign prev_lower  = lower[g-1];
      assign prev_pri[g] = slot_pri_q[g-1];
      assign prev_pay[g] = slot_pay_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign next_pri[g] = slot_pri_q[g];
      assign next_pay[g] = slot_pay_q[g];
    end else begin : g_mid
      assign next_pri[g] = slot_pri_q[g+1];
      assign next_pay[g] = slot_pay_q[g+1];
    end
    // lower is monotonic over held cells, so the first lower cell or the tail is the spot
    assign ins_at[g]   = !prev_lower && (lower[g] || (count_q == CNT_W'(g)));
    assign shift_dn[g] = prev_lower;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_push && ins_at[i]) begin
        slot_pri_q[i] <= pri_q;
        slot_pay_q[i] <= pay_q;
      end else if (do_push && shift_dn[i]) begin
        slot_pri_q[i] <= prev_pri[i];
        slot_pay_q[i] <= prev_pay[i];
      end else if (do_pop) begin
        slot_pri_q[i] <= next_pri[i];
        slot_pay_q[i] <= next_pay[i];
      end
    end
  end

  always_comb begin
    count_d      = count_q;
    serving_d    = serving_q;
    res_pri_d    = '0;
    res_pay_d    = '0;
    res_status_d = ST_PUSH_REFUSE;
    if (op_q == OP_PUSH) begin
      if (!full) begin
        count_d      = count_q + CNT_W'(1);
        res_status_d = empty ? ST_PUSH_EMPTY : ST_PUSHED;
      end
    end else if (empty) begin
      res_status_d = ST_POP_EMPTY;
    end else begin
      count_d      = count_q - CNT_W'(1);
      serving_d    = slot_pri_q[0];
      res_pri_d    = slot_pri_q[0];
      res_pay_d    = slot_pay_q[0];
      res_status_d = ST_POPPED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      serving_q <= PRIORITY_BITS'(1);
    end else if (cmd_i.exec) begin
      count_q   <= count_d;
      serving_q <= serving_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= opcode_i;
      pri_q <= item_priority_i;
      pay_q <= payload_tag_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_pri_q    <= res_pri_d;
      res_pay_q    <= res_pay_d;
      res_cnt_q    <= count_d;
      res_serv_q   <= serving_d;
    end
  end

  assign status_o           = res_status_q;
  assign out_priority_o     = res_pri_q;
  assign out_payload_o      = res_pay_q;
  assign pending_count_o    = res_cnt_q;
  assign serving_priority_o = res_serv_q;

endmodule

`default_nettype wire

@@ sv/pmq_checker.sv @@
// port-level checks of the priority message queue, bound to the top level
// depends on pmq_pkg and priority_message_queue_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "priority_message_queue_core_defines.svh"

module pmq_checker #(
  parameter int unsigned QUEUE_DEPTH   = pmq_pkg::PMQ_QUEUE_DEPTH,
  parameter int unsigned PRIORITY_BITS = pmq_pkg::PMQ_PRIORITY_BITS,
  parameter int unsigned PAYLOAD_BITS  = pmq_pkg::PMQ_PAYLOAD_BITS,
  localparam int unsigned CNT_W        = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_i,
  input wire logic                     out_valid_i,
  input wire logic                     out_ready_i,
  input wire logic [pmq_pkg::STATUS_W-1:0] status_i,
  input wire logic [PRIORITY_BITS-1:0] out_priority_i,
  input wire logic [PAYLOAD_BITS-1:0]  out_payload_i,
  input wire logic [CNT_W-1:0]         pending_count_i
);
  import pmq_pkg::*;

  // one word in flight: after an accept the request side is busy
  `PMQ_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i,
                  "request accepted while previous one still executing")

  `PMQ_ASSERT_NXT(a_result_holds, out_valid_i && !out_ready_i,
                  out_valid_i && $stable(status_i) && $stable(pending_count_i),
                  "stalled result changed")

  `PMQ_ASSERT_IMP(a_count_matches_status, out_valid_i,
                  (pending_count_i <= CNT_W'(QUEUE_DEPTH)) &&
                  ((status_i != ST_PUSH_EMPTY) || (pending_count_i == CNT_W'(1))) &&
                  ((status_i != ST_POP_EMPTY) || (pending_count_i == '0)) &&
                  ((status_i != ST_PUSH_REFUSE) || (pending_count_i == CNT_W'(QUEUE_DEPTH))),
                  "pending count inconsistent with status")

  `PMQ_ASSERT_IMP(a_data_zero_unless_popped, out_valid_i && (status_i != ST_POPPED),
                  (out_priority_i == '0) && (out_payload_i == '0),
                  "message data on a result that is not a pop")

endmodule

bind priority_message_queue_core pmq_checker #(
  .QUEUE_DEPTH   (QUEUE_DEPTH),
  .PRIORITY_BITS (PRIORITY_BITS),
  .PAYLOAD_BITS  (PAYLOAD_BITS)
) u_pmq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .out_priority_i  (out_o.out_priority),
  .out_payload_i   (out_o.out_payload),
  .pending_count_i (out_o.pending_count)
);

`default_nettype wire
